// ===== src/wrsi_pkg.sv =====
`default_nettype none

package wrsi_pkg;

    localparam int RSI_INT_BITS  = 7;
    localparam int RSI_HUNDRED   = 100;
    localparam int PERIOD_RESET  = 14;
    localparam int APB_ADDR_BITS = 2;
    localparam int APB_DATA_BITS = 32;

    localparam logic [APB_ADDR_BITS-1:0] REG_PERIOD = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MUL,
        S_GO,
        S_WAIT,
        S_RESULT,
        S_PUSH
    } state_t;

    typedef enum logic [1:0] {
        OP_GAIN,
        OP_LOSS,
        OP_RSI
    } op_t;

endpackage

`default_nettype wire

// ===== src/wrsi_in_if.sv =====
`default_nettype none

interface wrsi_in_if #(
    parameter int PRICE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] close_price;
    logic                  restart;

    modport source (output valid, close_price, restart, input ready);
    modport sink (input valid, close_price, restart, output ready);
endinterface

`default_nettype wire

// ===== src/wrsi_out_if.sv =====
`default_nettype none

interface wrsi_out_if #(
    parameter int VALUE_BITS = 23
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] rsi_value;
    logic                  rsi_valid;

    modport source (output valid, rsi_value, rsi_valid, input ready);
    modport sink (input valid, rsi_value, rsi_valid, output ready);
endinterface

`default_nettype wire

// ===== src/wrsi_div.sv =====
`default_nettype none

module wrsi_div #(
    parameter int REM_W = 49,
    parameter int Q_W   = 64,
    parameter int QO_W  = 48,
    parameter int CNT_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [REM_W-1:0] rem_init,
    input  wire logic [Q_W-1:0]   bits,
    input  wire logic [REM_W-1:0] divisor,
    output logic                  done,
    output logic [QO_W-1:0]       quotient
);
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   sh_reg, sh_next;
    logic [REM_W-1:0] dsr_reg, dsr_next;
    logic [QO_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           fit;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, sh_reg[Q_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fit   = trial >= {1'b0, dsr_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = rem_init;
            sh_next   = bits;
            dsr_next  = divisor;
            quo_next  = '0;
            cnt_next  = count;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fit ? diff[REM_W-1:0] : trial[REM_W-1:0];
            sh_next  = sh_reg << 1;
            quo_next = {quo_reg[QO_W-2:0], fit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/wilder_relative_strength_index.sv =====
`default_nettype none

// Wilder RSI over a stream of closing prices, one item in and one result item out.
// An item runs through one shared multiplier and one radix-2 divider that makes one
// quotient bit per cycle, so its length follows the divisions it needs. A restart item
// goes from input straight to output; a seeding item adds its move to the sums and
// then issues its result without division. The item that completes the seed and each
// smoothing item run the divider once for the gain and once for the loss, and once
// more for the index unless the loss average is zero.
// A new item is taken while the last result still waits to leave, but the item then
// holds in its last cycle until that result is taken. The period register sits at
// byte address 0 of the APB port and resets to 14; a period of 0 acts as 1.

module wilder_relative_strength_index #(
    parameter int PRICE_BITS  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int PERIOD_BITS = 10
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [wrsi_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [wrsi_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [wrsi_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready,
    wrsi_in_if.sink                                 price_in,
    wrsi_out_if.source                              rsi_out
);
    import wrsi_pkg::*;

    localparam int AVG_W  = PRICE_BITS + FRAC_BITS;
    localparam int VAL_W  = RSI_INT_BITS + FRAC_BITS;
    localparam int Q_MAX  = AVG_W + FRAC_BITS;
    localparam int SMTH_W = AVG_W + PERIOD_BITS + 1;
    localparam int RSI_DW = AVG_W + VAL_W;
    localparam int DVD_A  = (Q_MAX > SMTH_W) ? Q_MAX : SMTH_W;
    localparam int DVD_W  = (DVD_A > RSI_DW) ? DVD_A : RSI_DW;
    localparam int REM_W  = AVG_W + 1;
    localparam int CNT_W  = $clog2(Q_MAX + 1);
    localparam int MB_W   = (PERIOD_BITS > RSI_INT_BITS) ? PERIOD_BITS : RSI_INT_BITS;
    localparam int MUL_W  = AVG_W + MB_W;

    localparam logic [VAL_W-1:0] FULL = VAL_W'(RSI_HUNDRED) << FRAC_BITS;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   seed_reg, seed_next;

    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic [PERIOD_BITS-1:0] p_reg, p_next;
    logic [PERIOD_BITS-1:0] count_reg, count_next;
    logic [PRICE_BITS-1:0]  prev_reg, prev_next;
    logic [PRICE_BITS-1:0]  up_reg, up_next;
    logic [PRICE_BITS-1:0]  dn_reg, dn_next;
    logic [AVG_W-1:0]       gain_reg, gain_next;
    logic [AVG_W-1:0]       loss_reg, loss_next;
    logic [DVD_W-1:0]       prod_reg, prod_next;
    logic [VAL_W-1:0]       res_value_reg, res_value_next;
    logic                   res_flag_reg, res_flag_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]       out_value_reg, out_value_next;
    logic                   out_flag_reg, out_flag_next;

    logic [PERIOD_BITS-1:0] p_eff;
    logic [PERIOD_BITS-1:0] count_inc;
    logic                   seeding;
    logic                   in_ready;
    logic                   out_free;
    logic                   cfg_write;
    logic [AVG_W:0]         gain_sum;
    logic [AVG_W:0]         loss_sum;
    logic [AVG_W-1:0]       avg_sel;
    logic [MB_W-1:0]        mul_b;
    logic [MUL_W-1:0]       mul_out;
    logic [DVD_W-1:0]       addend;
    logic [DVD_W-1:0]       dvd;

    logic             div_start;
    logic [CNT_W-1:0] div_count;
    logic [REM_W-1:0] div_rem;
    logic [Q_MAX-1:0] div_bits;
    logic [REM_W-1:0] div_dsr;
    logic             div_done;
    logic [AVG_W-1:0] div_quo;

    wrsi_div #(
        .REM_W (REM_W),
        .Q_W   (Q_MAX),
        .QO_W  (AVG_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .count    (div_count),
        .rem_init (div_rem),
        .bits     (div_bits),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == REG_PERIOD) ? APB_DATA_BITS'(period_reg) : '0;

    assign p_eff     = (period_reg == '0) ? PERIOD_BITS'(1) : period_reg;
    assign count_inc = count_reg + PERIOD_BITS'(1);
    assign seeding   = count_reg < p_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsi_out.ready;

    assign price_in.ready    = in_ready;
    assign rsi_out.valid     = out_valid_reg;
    assign rsi_out.rsi_value = out_value_reg;
    assign rsi_out.rsi_valid = out_flag_reg;

    // shared multiplier and divider operands
    always_comb
    begin
        avg_sel = (op_reg == OP_LOSS) ? loss_reg : gain_reg;
        mul_b   = (op_reg == OP_RSI) ? MB_W'(RSI_HUNDRED) : MB_W'(p_reg - PERIOD_BITS'(1));
        mul_out = avg_sel * mul_b;
        gain_sum = {1'b0, gain_reg} + (AVG_W+1)'(up_reg);
        loss_sum = {1'b0, loss_reg} + (AVG_W+1)'(dn_reg);

        addend = '0;
        if (!seed_reg && (op_reg == OP_GAIN))
            addend = DVD_W'(up_reg) << FRAC_BITS;
        else if (!seed_reg && (op_reg == OP_LOSS))
            addend = DVD_W'(dn_reg) << FRAC_BITS;
        dvd = prod_reg + addend;

        // high dividend bits that cannot yield a quotient bit preload the remainder
        case (op_reg)
            OP_GAIN, OP_LOSS:
            begin
                div_dsr = REM_W'(p_reg);
                if (seed_reg)
                begin
                    div_count = CNT_W'(Q_MAX);
                    div_rem   = '0;
                    div_bits  = Q_MAX'(dvd);
                end
                else
                begin
                    div_count = CNT_W'(AVG_W);
                    div_rem   = REM_W'(dvd >> AVG_W);
                    div_bits  = Q_MAX'(dvd[AVG_W-1:0]) << (Q_MAX - AVG_W);
                end
            end
            default:
            begin
                div_dsr   = REM_W'(gain_reg) + REM_W'(loss_reg);
                div_count = CNT_W'(VAL_W);
                div_rem   = REM_W'(dvd >> VAL_W);
                div_bits  = Q_MAX'(dvd[VAL_W-1:0]) << (Q_MAX - VAL_W);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (price_in.valid)
                    state_next = price_in.restart ? S_PUSH : S_UPDATE;
            S_UPDATE:
                if (seeding && (count_inc != p_reg))
                    state_next = S_RESULT;
                else
                    state_next = S_MUL;
            S_MUL:
                state_next = S_GO;
            S_GO:
                state_next = S_WAIT;
            S_WAIT:
                if (div_done)
                begin
                    case (op_reg)
                        OP_GAIN: state_next = S_MUL;
                        OP_LOSS: state_next = S_RESULT;
                        default: state_next = S_PUSH;
                    endcase
                end
            S_RESULT:
                if ((count_reg >= p_reg) && (loss_reg != '0))
                    state_next = S_MUL;
                else
                    state_next = S_PUSH;
            S_PUSH:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        period_next    = period_reg;
        op_next        = op_reg;
        seed_next      = seed_reg;
        p_next         = p_reg;
        count_next     = count_reg;
        prev_next      = prev_reg;
        up_next        = up_reg;
        dn_next        = dn_reg;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        prod_next      = prod_reg;
        res_value_next = res_value_reg;
        res_flag_next  = res_flag_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_flag_next  = out_flag_reg;
        div_start      = 1'b0;

        if (cfg_write && (paddr == REG_PERIOD))
            period_next = pwdata[PERIOD_BITS-1:0];

        if (rsi_out.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
                if (price_in.valid)
                begin
                    prev_next = price_in.close_price;
                    p_next    = p_eff;
                    if (price_in.restart)
                    begin
                        gain_next      = '0;
                        loss_next      = '0;
                        count_next     = '0;
                        res_value_next = '0;
                        res_flag_next  = 1'b0;
                    end
                    else if (price_in.close_price > prev_reg)
                    begin
                        up_next = price_in.close_price - prev_reg;
                        dn_next = '0;
                    end
                    else
                    begin
                        up_next = '0;
                        dn_next = prev_reg - price_in.close_price;
                    end
                end
            S_UPDATE:
            begin
                op_next   = OP_GAIN;
                seed_next = seeding;
                if (seeding)
                begin
                    gain_next  = gain_sum[AVG_W] ? '1 : gain_sum[AVG_W-1:0];
                    loss_next  = loss_sum[AVG_W] ? '1 : loss_sum[AVG_W-1:0];
                    count_next = count_inc;
                end
            end
            S_MUL:
                if (op_reg == OP_RSI)
                    prod_next = DVD_W'(mul_out) << FRAC_BITS;
                else if (seed_reg)
                    prod_next = DVD_W'(avg_sel) << FRAC_BITS;
                else
                    prod_next = DVD_W'(mul_out);
            S_GO:
                div_start = 1'b1;
            S_WAIT:
                if (div_done)
                begin
                    case (op_reg)
                        OP_GAIN:
                        begin
                            gain_next = div_quo;
                            op_next   = OP_LOSS;
                        end
                        OP_LOSS:
                            loss_next = div_quo;
                        default:
                            res_value_next = div_quo[VAL_W-1:0];
                    endcase
                end
            S_RESULT:
            begin
                op_next        = OP_RSI;
                res_flag_next  = count_reg >= p_reg;
                res_value_next = ((count_reg >= p_reg) && (loss_reg == '0)) ? FULL : '0;
            end
            S_PUSH:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_flag_next  = res_flag_reg;
                end
            default:
                op_next = OP_GAIN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_GAIN;
            seed_reg      <= 1'b0;
            period_reg    <= PERIOD_BITS'(PERIOD_RESET);
            count_reg     <= '0;
            prev_reg      <= '0;
            gain_reg      <= '0;
            loss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            seed_reg      <= seed_next;
            period_reg    <= period_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            gain_reg      <= gain_next;
            loss_reg      <= loss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        up_reg        <= up_next;
        dn_reg        <= dn_next;
        prod_reg      <= prod_next;
        res_value_reg <= res_value_next;
        res_flag_reg  <= res_flag_next;
        out_value_reg <= out_value_next;
        out_flag_reg  <= out_flag_next;
    end

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsi_out.valid |-> (rsi_out.rsi_value <= FULL))
        else $error("rsi value above 100");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsi_out.valid && !rsi_out.rsi_valid) |-> (rsi_out.rsi_value == '0))
        else $error("nonzero value on item that is not valid");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_WAIT))
        else $error("divider finished outside wait state");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !div_done)
        else $error("divider done right after start");

endmodule

`default_nettype wire
